// ----- design/cdf_pkg.sv -----
// Package for the Coulomb friction damper force block.
// Holds register indexes, operation and damp-out codes, reset values and the stage enable type.
// No dependencies.
`timescale 1ns / 1ps

package cdf_pkg;

	localparam int unsigned DataW  = 64;
	localparam int unsigned MagW   = 63;
	localparam int unsigned FlipW  = 8;
	localparam int unsigned ShiftW = 9;
	localparam int unsigned AddrW  = 6;
	localparam int unsigned ProdW  = 2 * DataW;

	// Register indexes, taken from paddr[5:3].
	localparam logic [2:0] REG_STIFFNESS     = 3'd0;
	localparam logic [2:0] REG_FRICTION      = 3'd1;
	localparam logic [2:0] REG_TOLERANCE     = 3'd2;
	localparam logic [2:0] REG_LINEAR_GAIN   = 3'd3;
	localparam logic [2:0] REG_DAMP_OUT_GAIN = 3'd4;
	localparam logic [2:0] REG_DAMP_MODE     = 3'd5;
	localparam logic [2:0] REG_FLIP_LIMIT    = 3'd6;

	// Operation codes.
	localparam logic [1:0] OP_TRIAL   = 2'd0;
	localparam logic [1:0] OP_COMMIT  = 2'd1;
	localparam logic [1:0] OP_REVERT  = 2'd2;
	localparam logic [1:0] OP_RESTART = 2'd3;

	// Damp-out modes.
	localparam logic [1:0] DAMP_LINEAR   = 2'd1;
	localparam logic [1:0] DAMP_FRICTION = 2'd2;
	localparam logic [1:0] DAMP_VISCOUS  = 2'd3;

	// Register reset values.
	localparam logic [DataW-1:0] RST_STIFFNESS     = 64'd0;
	localparam logic [MagW-1:0]  RST_FRICTION      = 63'd0;
	localparam logic [MagW-1:0]  RST_TOLERANCE     = 63'd4295;
	localparam logic [MagW-1:0]  RST_LINEAR_GAIN   = 63'd0;
	localparam logic [DataW-1:0] RST_DAMP_OUT_GAIN = 64'h0000_0001_0000_0000;
	localparam logic [1:0]       RST_DAMP_MODE     = DAMP_LINEAR;
	localparam logic [FlipW-1:0] RST_FLIP_LIMIT    = 8'd2;

	// Binary point position of Q32.32.
	localparam logic [ShiftW-1:0] FRAC_SHIFT = 9'd32;

	// Load enables of the pipeline stages after the state snapshot.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

endpackage

// ----- design/cdf_mul_shift.sv -----
// Pipelined signed 64 x 64 multiply, arithmetic right shift and saturation to 64 bits.
// Built from four 32 x 32 partial products; stages s2 to s6, result held in the s6 register.
// Depends on cdf_pkg.
`timescale 1ns / 1ps

module cdf_mul_shift (
	input  logic                                  clk,
	input  cdf_pkg::stage_en_t                    en,
	input  logic signed [cdf_pkg::DataW-1:0]      a,
	input  logic signed [cdf_pkg::DataW-1:0]      b,
	input  logic        [cdf_pkg::ShiftW-1:0]     shift,
	output logic signed [cdf_pkg::DataW-1:0]      result
);
	import cdf_pkg::*;

	localparam int unsigned HalfW = DataW / 2;

	logic [DataW-1:0]  mag_a, mag_b;
	logic [DataW-1:0]  mag_a_s2, mag_b_s2;
	logic              neg_s2, neg_s3, neg_s4, neg_s5;
	logic [ShiftW-1:0] shift_s2, shift_s3, shift_s4;

	logic [DataW-1:0]  ll_s3, lh_s3, hl_s3, hh_s3;
	logic [ProdW-1:0]  prod, prod_s4;

	logic [ProdW-1:0]  quot, rem_mask;
	logic [DataW:0]    quot_s5;
	logic              big_s5, rem_s5;

	logic [DataW+1:0]  rounded;
	logic              sat_pos, sat_neg;
	logic [DataW-1:0]  res_val;
	logic [DataW-1:0]  result_s6;

	assign mag_a = a[DataW-1] ? (~a + 1'b1) : a;
	assign mag_b = b[DataW-1] ? (~b + 1'b1) : b;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			mag_a_s2 <= mag_a;
			mag_b_s2 <= mag_b;
			neg_s2   <= a[DataW-1] ^ b[DataW-1];
			shift_s2 <= shift;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ll_s3    <= mag_a_s2[HalfW-1:0]     * mag_b_s2[HalfW-1:0];
			lh_s3    <= mag_a_s2[HalfW-1:0]     * mag_b_s2[DataW-1:HalfW];
			hl_s3    <= mag_a_s2[DataW-1:HalfW] * mag_b_s2[HalfW-1:0];
			hh_s3    <= mag_a_s2[DataW-1:HalfW] * mag_b_s2[DataW-1:HalfW];
			neg_s3   <= neg_s2;
			shift_s3 <= shift_s2;
		end
	end

	assign prod = {hh_s3, {DataW{1'b0}}}
		+ {{HalfW{1'b0}}, lh_s3, {HalfW{1'b0}}}
		+ {{HalfW{1'b0}}, hl_s3, {HalfW{1'b0}}}
		+ {{DataW{1'b0}}, ll_s3};

	always_ff @(posedge clk) begin
		if (en.s4) begin
			prod_s4  <= prod;
			neg_s4   <= neg_s3;
			shift_s4 <= shift_s3;
		end
	end

	// Shifts of 128 or more leave nothing in the quotient and the whole product as remainder.
	assign quot     = prod_s4 >> shift_s4;
	assign rem_mask = ~({ProdW{1'b1}} << shift_s4);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			quot_s5 <= quot[DataW:0];
			big_s5  <= |quot[ProdW-1:DataW+1];
			rem_s5  <= |(prod_s4 & rem_mask);
			neg_s5  <= neg_s4;
		end
	end

	// A negative product with a remainder rounds its magnitude up, toward minus infinity.
	assign rounded = {1'b0, quot_s5} + {{(DataW+1){1'b0}}, neg_s5 & rem_s5};
	assign sat_pos = big_s5 || (|rounded[DataW+1:DataW-1]);
	assign sat_neg = big_s5 || (|rounded[DataW+1:DataW])
		|| (rounded[DataW-1] && (|rounded[DataW-2:0]));

	always_comb begin
		if (neg_s5) begin
			res_val = sat_neg ? {1'b1, {(DataW-1){1'b0}}} : (~rounded[DataW-1:0] + 1'b1);
		end else begin
			res_val = sat_pos ? {1'b0, {(DataW-1){1'b1}}} : rounded[DataW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			result_s6 <= res_val;
		end
	end

	assign result = result_s6;

endmodule

// ----- design/coulomb_damper_force.sv -----
// Coulomb friction damper force: an accepted item passes through the state snapshot, the five
// register stages of the split 64 x 64 multipliers (operand magnitudes, partial products, sum,
// shift, round) and the result register to its result beat. Throughput one item per cycle while
// result_ready does not stall the output.
// Reset (arst_n low, asynchronous) zeroes the state and loads the register defaults.
// Depends on cdf_pkg and cdf_mul_shift.
`timescale 1ns / 1ps

module coulomb_damper_force (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic        [1:0]                   operation,
	input  logic signed [cdf_pkg::DataW-1:0]    strain,
	input  logic signed [cdf_pkg::DataW-1:0]    strain_rate,

	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [cdf_pkg::DataW-1:0]    stress,
	output logic signed [cdf_pkg::DataW-1:0]    damp_tangent,
	output logic        [cdf_pkg::FlipW-1:0]    flip_count,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic        [cdf_pkg::AddrW-1:0]    paddr,
	input  logic        [cdf_pkg::DataW-1:0]    pwdata,
	output logic        [cdf_pkg::DataW-1:0]    prdata,
	output logic                                pready
);
	import cdf_pkg::*;

	// Configuration registers.
	logic [DataW-1:0] stiffness_q, damp_out_gain_q;
	logic [MagW-1:0]  friction_q, tolerance_q, linear_gain_q;
	logic [1:0]       damp_mode_q;
	logic [FlipW-1:0] flip_limit_q;

	logic             cfg_write;
	logic [2:0]       cfg_index;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_index = paddr[AddrW-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q     <= RST_STIFFNESS;
			friction_q      <= RST_FRICTION;
			tolerance_q     <= RST_TOLERANCE;
			linear_gain_q   <= RST_LINEAR_GAIN;
			damp_out_gain_q <= RST_DAMP_OUT_GAIN;
			damp_mode_q     <= RST_DAMP_MODE;
			flip_limit_q    <= RST_FLIP_LIMIT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_STIFFNESS:     stiffness_q     <= pwdata;
				REG_FRICTION:      friction_q      <= pwdata[MagW-1:0];
				REG_TOLERANCE:     tolerance_q     <= pwdata[MagW-1:0];
				REG_LINEAR_GAIN:   linear_gain_q   <= pwdata[MagW-1:0];
				REG_DAMP_OUT_GAIN: damp_out_gain_q <= pwdata;
				REG_DAMP_MODE:     damp_mode_q     <= pwdata[1:0];
				REG_FLIP_LIMIT:    flip_limit_q    <= pwdata[FlipW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_index)
			REG_STIFFNESS:     prdata = stiffness_q;
			REG_FRICTION:      prdata = {1'b0, friction_q};
			REG_TOLERANCE:     prdata = {1'b0, tolerance_q};
			REG_LINEAR_GAIN:   prdata = {1'b0, linear_gain_q};
			REG_DAMP_OUT_GAIN: prdata = damp_out_gain_q;
			REG_DAMP_MODE:     prdata = {{(DataW-2){1'b0}}, damp_mode_q};
			REG_FLIP_LIMIT:    prdata = {{(DataW-FlipW){1'b0}}, flip_limit_q};
			default:           prdata = '0;
		endcase
	end

	// Stage enables: a stage loads when it is empty or the stage after it moves on.
	logic      v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	logic      result_valid_q;
	logic      en1, en2, en3, en4, en5, en6, en_out;
	logic      accept;
	stage_en_t stage_en;

	assign en_out     = !result_valid_q || result_ready;
	assign en6        = !v6_s6 || en_out;
	assign en5        = !v5_s5 || en6;
	assign en4        = !v4_s4 || en5;
	assign en3        = !v3_s3 || en4;
	assign en2        = !v2_s2 || en3;
	assign en1        = !v1_s1 || en2;
	assign item_ready = en1;
	assign accept     = item_valid && en1;

	assign stage_en = '{s2: en2, s3: en3, s4: en4, s5: en5, s6: en6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1          <= 1'b0;
			v2_s2          <= 1'b0;
			v3_s3          <= 1'b0;
			v4_s4          <= 1'b0;
			v5_s5          <= 1'b0;
			v6_s6          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (en1)    v1_s1          <= item_valid;
			if (en2)    v2_s2          <= v1_s1;
			if (en3)    v3_s3          <= v2_s2;
			if (en4)    v4_s4          <= v3_s3;
			if (en5)    v5_s5          <= v4_s4;
			if (en6)    v6_s6          <= v5_s5;
			if (en_out) result_valid_q <= v6_s6;
		end
	end

	// Material state, updated at the beat that accepts an item.
	logic signed [DataW-1:0] current_strain_q, current_rate_q, committed_rate_q;
	logic        [FlipW-1:0] flips_q;
	logic signed [DataW-1:0] strain_d, rate_d, committed_d;
	logic        [FlipW-1:0] flips_d;
	logic signed [DataW-1:0] tol, neg_tol;
	logic                    flip;

	assign tol     = $signed({1'b0, tolerance_q});
	assign neg_tol = -tol;
	assign flip    = (committed_rate_q > 0 && strain_rate < neg_tol)
		|| (committed_rate_q < 0 && strain_rate > tol);

	always_comb begin
		strain_d    = current_strain_q;
		rate_d      = current_rate_q;
		committed_d = committed_rate_q;
		flips_d     = flips_q;
		case (operation)
			OP_TRIAL: begin
				strain_d = strain;
				rate_d   = strain_rate;
				if (flip && flips_q != {FlipW{1'b1}}) begin
					flips_d = flips_q + 1'b1;
				end
			end
			OP_COMMIT: begin
				committed_d = current_rate_q;
				flips_d     = '0;
			end
			OP_REVERT: begin
				rate_d  = committed_rate_q;
				flips_d = '0;
			end
			default: begin
				strain_d    = '0;
				rate_d      = '0;
				committed_d = '0;
				flips_d     = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_strain_q <= '0;
			current_rate_q   <= '0;
			committed_rate_q <= '0;
			flips_q          <= '0;
		end else if (accept) begin
			current_strain_q <= strain_d;
			current_rate_q   <= rate_d;
			committed_rate_q <= committed_d;
			flips_q          <= flips_d;
		end
	end

	// Snapshot of the state after the operation.
	logic signed [DataW-1:0] strain_s1, rate_s1;
	logic        [FlipW-1:0] flips_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			strain_s1 <= strain_d;
			rate_s1   <= rate_d;
			flips_s1  <= flips_d;
		end
	end

	// Friction term selection: either a product or a fixed force, and the tangent.
	logic        [FlipW-1:0]  halvings;
	logic        [FlipW:0]    flips_inc;
	logic                     damped, r_pos, r_neg, in_band;
	logic                     use_prod;
	logic signed [DataW-1:0]  force_const, tangent, fric_op;
	logic        [ShiftW-1:0] fric_shift;
	logic        [MagW-1:0]   fric_halved;

	assign flips_inc   = {1'b0, flips_s1} + 1'b1;
	assign halvings    = flips_inc[FlipW:1];
	assign damped      = flips_s1 > flip_limit_q;
	assign r_pos       = rate_s1 > tol;
	assign r_neg       = rate_s1 < neg_tol;
	assign in_band     = rate_s1 > neg_tol && rate_s1 < tol;
	assign fric_halved = friction_q >> halvings;

	always_comb begin
		use_prod    = 1'b0;
		force_const = '0;
		tangent     = '0;
		fric_op     = $signed({1'b0, linear_gain_q});
		fric_shift  = FRAC_SHIFT;
		if (damped) begin
			case (damp_mode_q)
				DAMP_LINEAR: begin
					use_prod   = 1'b1;
					fric_shift = FRAC_SHIFT + {1'b0, halvings};
					tangent    = $signed({1'b0, linear_gain_q >> halvings});
				end
				DAMP_FRICTION: begin
					if (r_pos) begin
						force_const = $signed({1'b0, fric_halved});
					end else if (r_neg) begin
						force_const = -$signed({1'b0, fric_halved});
					end
				end
				DAMP_VISCOUS: begin
					use_prod = 1'b1;
					fric_op  = damp_out_gain_q;
					tangent  = damp_out_gain_q;
				end
				default: ;
			endcase
		end else if (in_band) begin
			use_prod = 1'b1;
			tangent  = $signed({1'b0, linear_gain_q});
		end else if (r_pos) begin
			force_const = $signed({1'b0, friction_q});
		end else if (r_neg) begin
			force_const = -$signed({1'b0, friction_q});
		end
	end

	logic signed [DataW-1:0] elastic_s6, fric_prod_s6;

	cdf_mul_shift u_elastic_mul (
		.clk    (clk),
		.en     (stage_en),
		.a      (stiffness_q),
		.b      (strain_s1),
		.shift  (FRAC_SHIFT),
		.result (elastic_s6)
	);

	cdf_mul_shift u_friction_mul (
		.clk    (clk),
		.en     (stage_en),
		.a      (fric_op),
		.b      (rate_s1),
		.shift  (fric_shift),
		.result (fric_prod_s6)
	);

	// Side data that travels alongside the multipliers.
	logic                    use_prod_s2, use_prod_s3, use_prod_s4, use_prod_s5, use_prod_s6;
	logic signed [DataW-1:0] force_const_s2, force_const_s3, force_const_s4, force_const_s5;
	logic signed [DataW-1:0] force_const_s6;
	logic signed [DataW-1:0] tangent_s2, tangent_s3, tangent_s4, tangent_s5, tangent_s6;
	logic        [FlipW-1:0] flips_s2, flips_s3, flips_s4, flips_s5, flips_s6;

	always_ff @(posedge clk) begin
		if (en2) begin
			use_prod_s2    <= use_prod;
			force_const_s2 <= force_const;
			tangent_s2     <= tangent;
			flips_s2       <= flips_s1;
		end
		if (en3) begin
			use_prod_s3    <= use_prod_s2;
			force_const_s3 <= force_const_s2;
			tangent_s3     <= tangent_s2;
			flips_s3       <= flips_s2;
		end
		if (en4) begin
			use_prod_s4    <= use_prod_s3;
			force_const_s4 <= force_const_s3;
			tangent_s4     <= tangent_s3;
			flips_s4       <= flips_s3;
		end
		if (en5) begin
			use_prod_s5    <= use_prod_s4;
			force_const_s5 <= force_const_s4;
			tangent_s5     <= tangent_s4;
			flips_s5       <= flips_s4;
		end
		if (en6) begin
			use_prod_s6    <= use_prod_s5;
			force_const_s6 <= force_const_s5;
			tangent_s6     <= tangent_s5;
			flips_s6       <= flips_s5;
		end
	end

	// Saturating sum of the elastic and friction parts.
	logic signed [DataW-1:0] force_s6, stress_val;
	logic        [DataW:0]   stress_sum;

	assign force_s6   = use_prod_s6 ? fric_prod_s6 : force_const_s6;
	assign stress_sum = {elastic_s6[DataW-1], elastic_s6} + {force_s6[DataW-1], force_s6};

	always_comb begin
		if (stress_sum[DataW] != stress_sum[DataW-1]) begin
			stress_val = stress_sum[DataW] ? {1'b1, {(DataW-1){1'b0}}}
				: {1'b0, {(DataW-1){1'b1}}};
		end else begin
			stress_val = stress_sum[DataW-1:0];
		end
	end

	logic signed [DataW-1:0] stress_q, damp_tangent_q;
	logic        [FlipW-1:0] flip_count_q;

	always_ff @(posedge clk) begin
		if (en_out) begin
			stress_q       <= stress_val;
			damp_tangent_q <= tangent_s6;
			flip_count_q   <= flips_s6;
		end
	end

	assign result_valid = result_valid_q;
	assign stress       = stress_q;
	assign damp_tangent = damp_tangent_q;
	assign flip_count   = flip_count_q;

	// Anything other than a trial clears the flip count.
	a_flips_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation != OP_TRIAL |=> flips_q == '0)
		else $error("flip count not cleared after commit, revert or restart");

	// A revert to commit leaves the current rate equal to the committed rate.
	a_revert_rate: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == OP_REVERT |=> current_rate_q == committed_rate_q)
		else $error("current rate differs from committed rate after revert");

	// The input side only stalls when the first stage holds an item it cannot pass on.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> v1_s1 && v2_s2 && v6_s6 && result_valid_q && !result_ready)
		else $error("input stalled while the pipeline has room");

endmodule
